/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssvm_pkg.sv */
// ----------------------------------------------------------------------------
// ssvm_pkg
// Types and constants of the spatial sample voice mixer.
// ----------------------------------------------------------------------------
package ssvm_pkg;

    localparam int CLIP_DEPTH_DEF = 16384;
    localparam int MIX_WIDTH_DEF  = 24;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_SRC     = 3'd1;
    localparam logic [2:0] OP_LST     = 3'd2;
    localparam logic [2:0] OP_EAR     = 3'd3;
    localparam logic [2:0] OP_MIX     = 3'd4;
    localparam logic [2:0] OP_RESTART = 3'd5;
    localparam logic [2:0] OP_RSVD6   = 3'd6;
    localparam logic [2:0] OP_RSVD7   = 3'd7;

    localparam logic [2:0] REG_GAIN    = 3'd0;
    localparam logic [2:0] REG_INNER   = 3'd1;
    localparam logic [2:0] REG_OUTER   = 3'd2;
    localparam logic [2:0] REG_LOOP    = 3'd3;
    localparam logic [2:0] REG_SPATIAL = 3'd4;
    localparam logic [2:0] REG_CLEN    = 3'd5;

    localparam logic [16:0] GAIN_ONE  = 17'd65536;
    localparam logic [16:0] PRES_MIN  = 17'd13107;
    localparam int          DIV_BITS  = 20;
    localparam int          SQRT_BITS = 31;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [13:0]        clip_address;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_right;
        logic signed [23:0] vec_x;
        logic signed [23:0] vec_y;
        logic signed [23:0] vec_z;
        logic signed [23:0] mix_left_in;
        logic signed [23:0] mix_right_in;
    } t_in_req;

    typedef struct packed {
        logic signed [23:0] mix_left_out;
        logic signed [23:0] mix_right_out;
        logic               still_playing;
        logic               audible;
        logic               clipped;
    } t_out_res;

endpackage

/* rtl/spatial_sample_voice_mixer.sv */
// ----------------------------------------------------------------------------
// spatial_sample_voice_mixer
// Stereo clip playback voice mixed into a stereo bus, plain or with distance
// attenuation and per-ear presence.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  in        input      i_in_valid / o_in_ready         t_in_req
//  out       output     o_out_valid / i_out_ready       t_out_res
//  cfg       input      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
//  Load, position, ear and restart requests are done in S_IDLE, which stays ready.
//  A plain mix runs S_RD, S_GET, S_PLN, S_ADD; a spatial mix adds the one-bit-per-
//  cycle square root (31 steps) and the shared divider, run up to twice (20 steps).
//  One request is in work at a time; a finished result waits in the output
//  register while the next request is taken.
//  Reset is synchronous; the clip memory is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spatial_sample_voice_mixer
    import ssvm_pkg::*;
#(
    parameter int CLIP_DEPTH = CLIP_DEPTH_DEF,
    parameter int MIX_WIDTH  = MIX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_res    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(CLIP_DEPTH);
    localparam int LW = $clog2(CLIP_DEPTH + 1);
    localparam logic signed [33:0] MIX_HI = 34'((64'sd1 <<< (MIX_WIDTH - 1)) - 64'sd1);
    localparam logic signed [33:0] MIX_LO = -MIX_HI - 34'sd1;
    localparam logic signed [52:0] RND_SP = 53'sh1_0000_0000;
    localparam logic signed [52:0] RND_PL = 53'sh1_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_GET, S_DIFF, S_ACC, S_CMP, S_SQRT, S_ATT,
        S_DOT, S_DIV, S_GAIN, S_SUM, S_PRES, S_PLN, S_ADD, S_DONE
    } t_state;

    function automatic logic [16:0] f_pres(input logic signed [20:0] dot);
        logic signed [21:0] p;
        p = 22'sd65536 - 22'(dot);
        if (dot <= 21'sd0) begin
            return GAIN_ONE;
        end else if (p < 22'sd13107) begin
            return PRES_MIN;
        end else begin
            return p[16:0];
        end
    endfunction

    // configuration
    logic [16:0] r_gain;
    logic [22:0] r_inner;
    logic [22:0] r_outer;
    logic        r_loop;
    logic        r_spatial;
    logic [14:0] r_clen;
    logic        w_cfg_wr;
    logic [16:0] w_gain_wr;

    // control
    t_state      r_state;
    t_in_req     r_item;
    logic [AW-1:0] r_pos;
    logic        r_playing;
    logic        r_active;
    logic        r_silent;
    logic [4:0]  r_cnt;
    logic [1:0]  r_k;
    logic        r_dphase;
    logic        r_dneg;
    logic        r_out_valid;
    t_out_res    r_out;

    // geometry and datapath
    logic signed [23:0] r_src [3];
    logic signed [23:0] r_lst [3];
    logic signed [15:0] r_ear [3];
    logic signed [24:0] r_d [3];
    logic [31:0]        r_mem [CLIP_DEPTH];
    logic [31:0]        r_rd;
    logic signed [15:0] r_sl;
    logic signed [15:0] r_sr;
    logic [45:0]        r_osq;
    logic [45:0]        r_isq;
    logic [49:0]        r_sq;
    logic [49:0]        r_sqp;
    logic signed [42:0] r_num;
    logic signed [40:0] r_nump;
    logic [61:0]        r_rad;
    logic [33:0]        r_rem;
    logic [30:0]        r_root;
    logic [30:0]        r_drem;
    logic [DIV_BITS-1:0] r_dlow;
    logic [DIV_BITS-1:0] r_dquo;
    logic [30:0]        r_ddiv;
    logic [16:0]        r_att;
    logic signed [20:0] r_dot;
    logic [16:0]        r_g;
    logic signed [34:0] r_s;
    logic signed [52:0] r_pl;
    logic signed [52:0] r_pr;
    logic signed [17:0] r_add_l;
    logic signed [17:0] r_add_r;

    // combinational
    logic               w_in_acc;
    logic               w_out_load;
    logic [31:0]        w_len32;
    logic [LW-1:0]      w_len;
    logic [AW-1:0]      w_pos_eff;
    logic [LW-1:0]      w_pos_inc;
    logic               w_wrap;
    logic               w_adv;
    logic               n_playing;
    logic signed [24:0] w_dk;
    logic signed [15:0] w_ek;
    logic signed [49:0] w_sqp;
    logic signed [40:0] w_nump;
    logic [33:0]        w_rem_sh;
    logic [33:0]        w_trial;
    logic [31:0]        w_dt;
    logic               w_dge;
    logic [DIV_BITS-1:0] n_dquo;
    logic [28:0]        w_att_num;
    logic [42:0]        w_nmag;
    logic [33:0]        w_ag;
    logic signed [16:0] w_ss;
    logic signed [34:0] w_s;
    logic signed [20:0] w_ndot;
    logic signed [52:0] w_rl;
    logic signed [52:0] w_rr;
    logic signed [52:0] w_shl;
    logic signed [52:0] w_shr;
    logic signed [33:0] w_sum_l;
    logic signed [33:0] w_sum_r;
    logic signed [33:0] w_sat_l;
    logic signed [33:0] w_sat_r;
    logic               w_hit_l;
    logic               w_hit_r;
    t_out_res           w_res;

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign w_gain_wr   = (pwdata[16:0] > GAIN_ONE) ? GAIN_ONE : pwdata[16:0];

    always_comb begin
        unique case (paddr[4:2])
            REG_GAIN:    prdata = 32'(r_gain);
            REG_INNER:   prdata = 32'(r_inner);
            REG_OUTER:   prdata = 32'(r_outer);
            REG_LOOP:    prdata = 32'(r_loop);
            REG_SPATIAL: prdata = 32'(r_spatial);
            REG_CLEN:    prdata = 32'(r_clen);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_ONE;
            r_inner   <= '0;
            r_outer   <= 23'h7FFFFF;
            r_loop    <= 1'b0;
            r_spatial <= 1'b0;
            r_clen    <= 15'd16384;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_GAIN:    r_gain    <= w_gain_wr;
                REG_INNER:   r_inner   <= pwdata[22:0];
                REG_OUTER:   r_outer   <= pwdata[22:0];
                REG_LOOP:    r_loop    <= pwdata[0];
                REG_SPATIAL: r_spatial <= pwdata[0];
                REG_CLEN:    r_clen    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // clip length and position
    always_comb begin
        if (r_clen == 15'd0) begin
            w_len32 = 32'd1;
        end else if (32'(r_clen) > 32'(CLIP_DEPTH)) begin
            w_len32 = 32'(CLIP_DEPTH);
        end else begin
            w_len32 = 32'(r_clen);
        end
    end
    assign w_len     = w_len32[LW-1:0];
    assign w_pos_eff = (LW'(r_pos) >= w_len) ? '0 : r_pos;
    assign w_pos_inc = LW'(r_pos) + LW'(1);
    assign w_wrap    = (w_pos_inc >= w_len);
    assign w_adv     = r_active && !r_silent;
    assign n_playing = (w_adv && w_wrap && !r_loop) ? 1'b0 : r_playing;

    // clip memory
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.opcode == OP_LOAD) &&
            (32'(i_in_data.clip_address) < 32'(CLIP_DEPTH))) begin
            r_mem[AW'(i_in_data.clip_address)] <= {i_in_data.clip_right,
                                                    i_in_data.clip_left};
        end
        r_rd <= r_mem[w_pos_eff];
    end

    // geometry
    always_comb begin
        unique case (r_k)
            2'd1:    begin w_dk = r_d[1]; w_ek = r_ear[1]; end
            2'd2:    begin w_dk = r_d[2]; w_ek = r_ear[2]; end
            default: begin w_dk = r_d[0]; w_ek = r_ear[0]; end
        endcase
    end
    assign w_sqp  = w_dk * w_dk;
    assign w_nump = w_dk * w_ek;

    // square root step
    assign w_rem_sh = {r_rem[31:0], r_rad[61:60]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    // divider step
    assign w_dt   = {r_drem, r_dlow[DIV_BITS-1]};
    assign w_dge  = (w_dt >= {1'b0, r_ddiv});
    assign n_dquo = {r_dquo[DIV_BITS-2:0], w_dge};

    assign w_att_num = 29'({r_outer, 6'b0} - 29'(r_root));
    assign w_nmag    = r_num[42] ? 43'(-r_num) : 43'(r_num);

    // gain and presence
    assign w_ag   = r_att * r_gain;
    assign w_ss   = 17'(r_sl) + 17'(r_sr);
    assign w_s    = w_ss * $signed({1'b0, r_g});
    assign w_ndot = -r_dot;
    assign w_rl   = r_pl + (r_spatial ? RND_SP : RND_PL);
    assign w_rr   = r_pr + (r_spatial ? RND_SP : RND_PL);
    assign w_shl  = r_spatial ? (w_rl >>> 33) : (w_rl >>> 17);
    assign w_shr  = r_spatial ? (w_rr >>> 33) : (w_rr >>> 17);

    // saturating add
    assign w_sum_l = 34'(r_item.mix_left_in) + 34'(r_add_l);
    assign w_sum_r = 34'(r_item.mix_right_in) + 34'(r_add_r);
    assign w_hit_l = (w_sum_l > MIX_HI) || (w_sum_l < MIX_LO);
    assign w_hit_r = (w_sum_r > MIX_HI) || (w_sum_r < MIX_LO);
    assign w_sat_l = (w_sum_l > MIX_HI) ? MIX_HI : ((w_sum_l < MIX_LO) ? MIX_LO : w_sum_l);
    assign w_sat_r = (w_sum_r > MIX_HI) ? MIX_HI : ((w_sum_r < MIX_LO) ? MIX_LO : w_sum_r);

    always_comb begin
        w_res.mix_left_out  = w_sat_l[23:0];
        w_res.mix_right_out = w_sat_r[23:0];
        w_res.still_playing = n_playing;
        w_res.audible       = w_adv;
        w_res.clipped       = w_hit_l || w_hit_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_playing   <= 1'b0;
            r_active    <= 1'b0;
            r_silent    <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_dphase    <= 1'b0;
            r_dneg      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_src[i] <= '0;
                r_lst[i] <= '0;
                r_ear[i] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_item <= i_in_data;
                        unique case (i_in_data.opcode)
                            OP_SRC: begin
                                r_src[0] <= i_in_data.vec_x;
                                r_src[1] <= i_in_data.vec_y;
                                r_src[2] <= i_in_data.vec_z;
                            end
                            OP_LST: begin
                                r_lst[0] <= i_in_data.vec_x;
                                r_lst[1] <= i_in_data.vec_y;
                                r_lst[2] <= i_in_data.vec_z;
                            end
                            OP_EAR: begin
                                r_ear[0] <= (i_in_data.vec_x > 24'sd32767) ? 16'sh7FFF :
                                            (i_in_data.vec_x < -24'sd32768) ? 16'sh8000 :
                                            i_in_data.vec_x[15:0];
                                r_ear[1] <= (i_in_data.vec_y > 24'sd32767) ? 16'sh7FFF :
                                            (i_in_data.vec_y < -24'sd32768) ? 16'sh8000 :
                                            i_in_data.vec_y[15:0];
                                r_ear[2] <= (i_in_data.vec_z > 24'sd32767) ? 16'sh7FFF :
                                            (i_in_data.vec_z < -24'sd32768) ? 16'sh8000 :
                                            i_in_data.vec_z[15:0];
                            end
                            OP_RESTART: begin
                                r_pos     <= '0;
                                r_playing <= 1'b1;
                            end
                            OP_MIX: begin
                                r_add_l  <= '0;
                                r_add_r  <= '0;
                                r_silent <= 1'b0;
                                r_active <= r_playing;
                                r_state  <= r_playing ? S_RD : S_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_pos   <= w_pos_eff;
                    r_state <= S_GET;
                end
                S_GET: begin
                    r_sl    <= r_rd[15:0];
                    r_sr    <= r_rd[31:16];
                    r_state <= r_spatial ? S_DIFF : S_PLN;
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_d[i] <= 25'(r_lst[i]) - 25'(r_src[i]);
                    end
                    r_osq   <= r_outer * r_outer;
                    r_isq   <= r_inner * r_inner;
                    r_sq    <= '0;
                    r_num   <= '0;
                    r_k     <= '0;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sqp  <= w_sqp;
                    r_nump <= w_nump;
                    if (r_k != 2'd0) begin
                        r_sq  <= r_sq + r_sqp;
                        r_num <= r_num + 43'(r_nump);
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_sq > {4'b0, r_osq}) begin
                        r_silent <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_rad   <= {r_sq, 12'b0};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_rad <= {r_rad[59:0], 2'b00};
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[29:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[29:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SQRT_BITS - 1)) begin
                        r_state <= S_ATT;
                    end
                end
                S_ATT: begin
                    if ({4'b0, r_isq} > r_sq) begin
                        r_att   <= GAIN_ONE;
                        r_state <= S_DOT;
                    end else if (r_outer == r_inner) begin
                        r_att   <= '0;
                        r_state <= S_DOT;
                    end else begin
                        r_drem   <= 31'({w_att_num, 16'b0} >> DIV_BITS);
                        r_dlow   <= DIV_BITS'({w_att_num, 16'b0});
                        r_ddiv   <= 31'({(r_outer - r_inner), 6'b0});
                        r_dquo   <= '0;
                        r_dphase <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DOT: begin
                    if (r_root == 31'd0) begin
                        r_dot   <= '0;
                        r_state <= S_GAIN;
                    end else begin
                        r_drem   <= 31'({w_nmag, 7'b0} >> DIV_BITS);
                        r_dlow   <= DIV_BITS'({w_nmag, 7'b0});
                        r_ddiv   <= r_root;
                        r_dquo   <= '0;
                        r_dneg   <= r_num[42];
                        r_dphase <= 1'b1;
                        r_cnt    <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_drem <= w_dge ? 31'(w_dt - {1'b0, r_ddiv}) : w_dt[30:0];
                    r_dlow <= {r_dlow[DIV_BITS-2:0], 1'b0};
                    r_dquo <= n_dquo;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_BITS - 1)) begin
                        if (!r_dphase) begin
                            r_att   <= n_dquo[16:0];
                            r_state <= S_DOT;
                        end else begin
                            r_dot   <= r_dneg ? -$signed({1'b0, n_dquo})
                                              : $signed({1'b0, n_dquo});
                            r_state <= S_GAIN;
                        end
                    end
                end
                S_GAIN: begin
                    r_g     <= w_ag[32:16];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_s     <= w_s;
                    r_state <= S_PRES;
                end
                S_PRES: begin
                    r_pl    <= r_s * $signed({1'b0, f_pres(w_ndot)});
                    r_pr    <= r_s * $signed({1'b0, f_pres(r_dot)});
                    r_state <= S_ADD;
                end
                S_PLN: begin
                    r_pl    <= r_sl * $signed({1'b0, r_gain});
                    r_pr    <= r_sr * $signed({1'b0, r_gain});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_add_l <= w_shl[17:0];
                    r_add_r <= w_shr[17:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        if (w_adv) begin
                            r_pos <= w_wrap ? '0 : AW'(w_pos_inc);
                        end
                        r_playing <= n_playing;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NXT(a_hold_pos, w_out_load && !w_res.audible, $stable(r_pos), "silent frame moved position")
    `ASSERT_IMP(a_play_drop, $fell(r_playing), ($past(r_state) == S_DONE) || !$past(i_rst_n), "playback stopped outside a mix result")
    `ASSERT_IMP(a_div_rem, r_state == S_DIV, r_drem < r_ddiv, "divider remainder out of range")
    `ASSERT_IMP(a_sqrt_rem, r_state == S_SQRT, r_rem[33:32] == 2'b00, "square root remainder overflow")

endmodule
